// ===== rtl/core/keypoint_brightness_filter_assert.svh =====
// Assertion macros shared by the keypoint brightness filter RTL.
// No dependencies; included inside module bodies.
`ifndef KEYPOINT_BRIGHTNESS_FILTER_ASSERT_SVH
`define KEYPOINT_BRIGHTNESS_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KBF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypoint brightness filter: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define KBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypoint brightness filter: assertion failed");

`endif

// ===== rtl/core/kbf_pkg.sv =====
// Shared types and constants of the keypoint brightness filter.
// No dependencies; used by kbf_regs and keypoint_brightness_filter.
package kbf_pkg;

    localparam int IMAGE_SIDE_DEF = 160;

    // Configuration port: five 32-bit registers at word addresses.
    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_RATIO  = 3'd0;
    localparam logic [2:0] REG_BRIGHT = 3'd1;
    localparam logic [2:0] REG_HALF   = 3'd2;
    localparam logic [2:0] REG_CFIRST = 3'd3;
    localparam logic [2:0] REG_CEND   = 3'd4;

    localparam logic [7:0] RATIO_RST  = 8'd12;
    localparam logic [7:0] BRIGHT_RST = 8'd140;
    localparam logic [5:0] HALF_RST   = 6'd16;
    localparam logic [7:0] CFIRST_RST = 8'd58;
    localparam logic [7:0] CEND_RST   = 8'd102;

    localparam logic [5:0] HALF_MAX = 6'd32;

    typedef struct packed {
        logic [7:0] ratio;
        logic [7:0] bright;
        logic [5:0] half;
        logic [7:0] cfirst;
        logic [7:0] cend;
    } t_cfg;

endpackage

// ===== rtl/core/kbf_regs.sv =====
// Configuration register file of the keypoint brightness filter (APB-style port).
// Depends on kbf_pkg for register indexes, reset values and the t_cfg struct.
module kbf_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [kbf_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output logic [31:0]                o_prdata,
    output kbf_pkg::t_cfg              o_cfg,
    output logic                       o_center_clr
);
    import kbf_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign idx   = i_paddr[CFG_AW-1:2];
    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio  <= RATIO_RST;
            r_cfg.bright <= BRIGHT_RST;
            r_cfg.half   <= HALF_RST;
            r_cfg.cfirst <= CFIRST_RST;
            r_cfg.cend   <= CEND_RST;
        end else if (wr_en) begin
            case (idx)
                REG_RATIO:  r_cfg.ratio  <= i_pwdata[7:0];
                REG_BRIGHT: r_cfg.bright <= i_pwdata[7:0];
                REG_HALF:   r_cfg.half   <= i_pwdata[5:0];
                REG_CFIRST: r_cfg.cfirst <= i_pwdata[7:0];
                REG_CEND:   r_cfg.cend   <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Moving the center square makes the cached center sum stale.
    assign o_center_clr = wr_en && ((idx == REG_CFIRST) || (idx == REG_CEND));

    always_comb begin
        case (idx)
            REG_RATIO:  o_prdata = {24'd0, r_cfg.ratio};
            REG_BRIGHT: o_prdata = {24'd0, r_cfg.bright};
            REG_HALF:   o_prdata = {26'd0, r_cfg.half};
            REG_CFIRST: o_prdata = {24'd0, r_cfg.cfirst};
            REG_CEND:   o_prdata = {24'd0, r_cfg.cend};
            default:    o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/keypoint_brightness_filter.sv =====
// Top level of the keypoint brightness filter: image store, scan sequencer, shared multiplier.
// Depends on kbf_pkg, kbf_regs and keypoint_brightness_filter_assert.svh.
//
//  Channel   | Direction | Handshake                    | Payload
//  ----------+-----------+------------------------------+-------------------------------------
//  command   | in        | start high while busy low    | i_command, i_point_x/y, i_gray
//  result    | out       | o_done high for one cycle    | o_keep, o_window_sum, o_window_area
//  config    | in/out    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A pixel write leaves busy low. A keypoint test keeps busy high through the window scan and
// the multiplications, and also through a scan of the center square when the center sum has
// to be recomputed; the image store's single port is read one pixel per cycle in the scans.
// o_done is high in the first cycle in which busy is low again. Reset is synchronous; the
// image store is not cleared. The receiver cannot stall results.
module keypoint_brightness_filter #(
    parameter int IMAGE_SIDE = kbf_pkg::IMAGE_SIDE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_command,
    input  logic [7:0]                 i_point_x,
    input  logic [7:0]                 i_point_y,
    input  logic [7:0]                 i_gray,
    output logic                       o_done,
    output logic                       o_keep,
    output logic [19:0]                o_window_sum,
    output logic [12:0]                o_window_area,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kbf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import kbf_pkg::*;
    `include "keypoint_brightness_filter_assert.svh"

    localparam int CW   = $clog2(IMAGE_SIDE + 1);
    localparam int XW   = (CW > 8) ? CW : 8;
    localparam int NPIX = IMAGE_SIDE * IMAGE_SIDE;
    localparam int AW   = $clog2(NPIX);
    localparam int CAW  = $clog2(NPIX + 1);
    localparam int MBW  = (CAW > 13) ? CAW : 13;
    localparam int PW   = 32 + MBW;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PREP   = 13'b0000000000010,
        S_CAREA  = 13'b0000000000100,
        S_WAREA  = 13'b0000000001000,
        S_CSCAN  = 13'b0000000010000,
        S_CDRAIN = 13'b0000000100000,
        S_WSCAN  = 13'b0000001000000,
        S_WDRAIN = 13'b0000010000000,
        S_MRC    = 13'b0000100000000,
        S_MRW    = 13'b0001000000000,
        S_ML     = 13'b0010000000000,
        S_MB     = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_cfg  cfg;
    logic  center_clr;

    kbf_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_cfg        (cfg),
        .o_center_clr (center_clr)
    );

    assign pready = 1'b1;

    t_state          r_state;
    logic [CW-1:0]   r_x, r_y;
    logic [CW-1:0]   r_lo, r_hi, r_left, r_right, r_top, r_bottom;
    logic [CW-1:0]   r_row, r_col, r_c0, r_c1, r_r1;
    logic [22:0]     r_acc, n_acc;
    logic [22:0]     r_csum;
    logic            r_center_valid;
    logic [19:0]     r_wsum;
    logic [CAW-1:0]  r_carea;
    logic [12:0]     r_warea;
    logic [30:0]     r_p1;
    logic [PW-1:0]   r_lhs, r_rhs;
    logic [20:0]     r_bprod;
    logic [7:0]      r_image [NPIX];
    logic [7:0]      r_rd_data;
    logic            r_rd_vld;
    logic            r_done, r_keep;
    logic [19:0]     r_window_sum;
    logic [12:0]     r_window_area;

    // ---------------------------------------------------------------- input beat
    logic          idle, px_ok, pix_we, test_go;
    logic [CW-1:0] x_sat, y_sat;
    logic [AW-1:0] wr_addr, scan_addr, mem_addr;

    assign idle    = (r_state == S_IDLE);
    assign busy    = !idle;
    assign px_ok   = (XW'(i_point_x) < XW'(IMAGE_SIDE)) && (XW'(i_point_y) < XW'(IMAGE_SIDE));
    assign pix_we  = idle && start && !i_command && px_ok;
    assign test_go = idle && start && i_command;
    assign x_sat   = (XW'(i_point_x) >= XW'(IMAGE_SIDE)) ? CW'(IMAGE_SIDE - 1) : CW'(i_point_x);
    assign y_sat   = (XW'(i_point_y) >= XW'(IMAGE_SIDE)) ? CW'(IMAGE_SIDE - 1) : CW'(i_point_y);

    assign wr_addr   = AW'(i_point_y) * AW'(IMAGE_SIDE) + AW'(i_point_x);
    assign scan_addr = AW'(r_row) * AW'(IMAGE_SIDE) + AW'(r_col);
    assign mem_addr  = pix_we ? wr_addr : scan_addr;

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_image[mem_addr] <= i_gray;
        end
        r_rd_data <= r_image[mem_addr];
    end

    // ---------------------------------------------------------------- bounds
    logic [5:0]  h_sat;
    logic [XW:0] xe, ye, he, side_e, rs, bs, cfe, cee;
    logic [XW:0] left_c, right_c, top_c, bottom_c, lo_c, hi_c;

    always_comb begin
        if (cfg.half == 6'd0) begin
            h_sat = 6'd1;
        end else if (cfg.half > HALF_MAX) begin
            h_sat = HALF_MAX;
        end else begin
            h_sat = cfg.half;
        end
        xe     = (XW + 1)'(r_x);
        ye     = (XW + 1)'(r_y);
        he     = (XW + 1)'(h_sat);
        side_e = (XW + 1)'(IMAGE_SIDE);
        rs     = xe + he;
        bs     = ye + he;
        left_c   = (xe > he) ? xe - he : '0;
        top_c    = (ye > he) ? ye - he : '0;
        right_c  = (rs > side_e) ? side_e : rs;
        bottom_c = (bs > side_e) ? side_e : bs;
        cfe  = (XW + 1)'(cfg.cfirst);
        cee  = (XW + 1)'(cfg.cend);
        lo_c = (cfe > side_e) ? side_e : cfe;
        hi_c = (cee > side_e) ? side_e : cee;
        if (hi_c < lo_c) begin
            hi_c = lo_c;
        end
    end

    // ---------------------------------------------------------------- shared multiplier
    logic [31:0]    mul_a;
    logic [MBW-1:0] mul_b;
    logic [PW-1:0]  mul_p;
    logic [23:0]    wsum10;

    assign wsum10 = ({4'd0, r_wsum} << 3) + ({4'd0, r_wsum} << 1);

    always_comb begin
        case (r_state)
            S_CAREA: begin
                mul_a = 32'(r_hi - r_lo);
                mul_b = MBW'(r_hi - r_lo);
            end
            S_WAREA: begin
                mul_a = 32'(r_right - r_left);
                mul_b = MBW'(r_bottom - r_top);
            end
            S_MRC: begin
                mul_a = 32'(r_csum);
                mul_b = MBW'(cfg.ratio);
            end
            S_MRW: begin
                mul_a = 32'(r_p1);
                mul_b = MBW'(r_warea);
            end
            S_ML: begin
                mul_a = 32'(wsum10);
                mul_b = MBW'(r_carea);
            end
            S_MB: begin
                mul_a = 32'(r_warea);
                mul_b = MBW'(cfg.bright);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // ---------------------------------------------------------------- scan counters
    logic [CW:0] col_inc, row_inc;
    logic        col_last, row_last, scan_end, scan_rd;

    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign col_last = (col_inc == {1'b0, r_c1});
    assign row_last = (row_inc == {1'b0, r_r1});
    assign scan_end = col_last && row_last;
    assign scan_rd  = (r_state == S_CSCAN) || (r_state == S_WSCAN);
    assign n_acc    = r_acc + (r_rd_vld ? 23'(r_rd_data) : 23'd0);

    logic drop;
    assign drop = (r_lhs > r_rhs) || ({1'b0, r_wsum} > r_bprod);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_center_valid <= 1'b0;
            r_csum         <= '0;
            r_rd_vld       <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= scan_rd;
            case (r_state)
                S_IDLE: begin
                    if (test_go) begin
                        r_x     <= x_sat;
                        r_y     <= y_sat;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_left   <= CW'(left_c);
                    r_right  <= CW'(right_c);
                    r_top    <= CW'(top_c);
                    r_bottom <= CW'(bottom_c);
                    r_lo     <= CW'(lo_c);
                    r_hi     <= CW'(hi_c);
                    r_state  <= S_CAREA;
                end
                S_CAREA: begin
                    r_carea <= mul_p[CAW-1:0];
                    r_state <= S_WAREA;
                end
                S_WAREA: begin
                    r_warea <= mul_p[12:0];
                    r_acc   <= '0;
                    if (!r_center_valid && (r_hi != r_lo)) begin
                        r_row   <= r_lo;
                        r_col   <= r_lo;
                        r_c0    <= r_lo;
                        r_c1    <= r_hi;
                        r_r1    <= r_hi;
                        r_state <= S_CSCAN;
                    end else begin
                        // An empty center square has a zero sum.
                        if (!r_center_valid) begin
                            r_csum         <= '0;
                            r_center_valid <= 1'b1;
                        end
                        r_row   <= r_top;
                        r_col   <= r_left;
                        r_c0    <= r_left;
                        r_c1    <= r_right;
                        r_r1    <= r_bottom;
                        r_state <= S_WSCAN;
                    end
                end
                S_CSCAN, S_WSCAN: begin
                    r_acc <= n_acc;
                    if (col_last) begin
                        r_col <= r_c0;
                        r_row <= CW'(row_inc);
                    end else begin
                        r_col <= CW'(col_inc);
                    end
                    if (scan_end) begin
                        r_state <= (r_state == S_CSCAN) ? S_CDRAIN : S_WDRAIN;
                    end
                end
                S_CDRAIN: begin
                    // The last pixel of the center square lands in this cycle.
                    r_csum         <= n_acc;
                    r_center_valid <= 1'b1;
                    r_acc          <= '0;
                    r_row          <= r_top;
                    r_col          <= r_left;
                    r_c0           <= r_left;
                    r_c1           <= r_right;
                    r_r1           <= r_bottom;
                    r_state        <= S_WSCAN;
                end
                S_WDRAIN: begin
                    r_wsum  <= n_acc[19:0];
                    r_state <= S_MRC;
                end
                S_MRC: begin
                    r_p1    <= mul_p[30:0];
                    r_state <= S_MRW;
                end
                S_MRW: begin
                    r_rhs   <= mul_p;
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_lhs   <= mul_p;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_bprod <= mul_p[20:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_done        <= 1'b1;
                    r_keep        <= !drop;
                    r_window_sum  <= r_wsum;
                    r_window_area <= r_warea;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Any change to the image or the center square makes the cached sum stale.
            if (pix_we || center_clr) begin
                r_center_valid <= 1'b0;
            end
        end
    end

    assign o_done        = r_done;
    assign o_keep        = r_keep;
    assign o_window_sum  = r_window_sum;
    assign o_window_area = r_window_area;

    // ---------------------------------------------------------------- assertions
    `KBF_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `KBF_ASSERT_NEXT(a_test_busy, i_clk, i_rst_n, start && !busy && i_command, busy)
    `KBF_ASSERT_SAME(a_end_result, i_clk, i_rst_n, $fell(busy), r_done)
    `KBF_ASSERT_SAME(a_read_pipe, i_clk, i_rst_n, r_rd_vld, $past(scan_rd))
    `KBF_ASSERT_SAME(a_area_nonzero, i_clk, i_rst_n, r_done, r_window_area != 13'd0)

endmodule
